FILE: rtl/per_device_report_filter_table_macros.svh
// assertion macros for the per-device report filter table
// used by the top level only, expects clk and rst_n in scope
`ifndef PER_DEVICE_REPORT_FILTER_TABLE_MACROS_SVH
`define PER_DEVICE_REPORT_FILTER_TABLE_MACROS_SVH

// same-cycle implication
`define PDRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/pdrf_pkg.sv
// shared types and constants for the per-device report filter table
// no dependencies
`default_nettype none

package pdrf_pkg;

    localparam int ADDR_W   = 48;
    localparam int WHOLE_W  = 7;
    localparam int TENTH_W  = 4;
    localparam int TEMP_W   = 1 + WHOLE_W + TENTH_W;
    localparam int HUM_W    = 7;
    localparam int TIME_W   = 32;
    localparam int IVL_W    = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;

    localparam logic [IVL_W-1:0] INTERVAL_RESET = 16'd300;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_SUPPRESSED  = 2'd0,
        STATUS_FORWARDED   = 2'd1,
        STATUS_SEND_FAILED = 2'd2,
        STATUS_TABLE_FULL  = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              sent_once;
        logic [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]  humidity;
        logic [TIME_W-1:0] sent_at;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/pdrf_ctrl.sv
// controller state machine: accept, table scan, decision and result load
// depends on pdrf_pkg
`default_nettype none

module pdrf_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  pdrf_pkg::dp_status_t   stat,
    output pdrf_pkg::ctrl_cmd_t    cmd
);
    import pdrf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.miss)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/pdrf_datapath.sv
// datapath: device table memory, scan counters, due check and result register
// depends on pdrf_pkg, driven by pdrf_ctrl commands
`default_nettype none

module pdrf_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  pdrf_pkg::ctrl_cmd_t              cmd,
    output pdrf_pkg::dp_status_t             stat,
    input  wire                              cfg_valid,
    input  wire [pdrf_pkg::IVL_W-1:0]        cfg_data,
    input  wire [pdrf_pkg::ADDR_W-1:0]       device_address,
    input  wire                              temp_negative,
    input  wire [pdrf_pkg::WHOLE_W-1:0]      temp_whole,
    input  wire [pdrf_pkg::TENTH_W-1:0]      temp_tenth,
    input  wire [pdrf_pkg::HUM_W-1:0]        humidity,
    input  wire [pdrf_pkg::TIME_W-1:0]       now_seconds,
    input  wire                              link_ready,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [pdrf_pkg::STATUS_W-1:0]    status,
    output logic [pdrf_pkg::INDEX_W-1:0]     entry_index,
    output logic [pdrf_pkg::ADDR_W-1:0]      report_address,
    output logic                             report_negative,
    output logic [pdrf_pkg::WHOLE_W-1:0]     report_whole,
    output logic [pdrf_pkg::TENTH_W-1:0]     report_tenth,
    output logic [pdrf_pkg::HUM_W-1:0]       report_humidity
);
    import pdrf_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];

    logic [IVL_W-1:0]    interval_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                neg_reg;
    logic [WHOLE_W-1:0]  whole_reg;
    logic [TENTH_W-1:0]  tenth_reg;
    logic [HUM_W-1:0]    hum_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                ready_reg;

    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                rd_valid_reg;
    entry_t              rd_data_reg;

    logic                out_valid_reg;
    status_code_t        status_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [ADDR_W-1:0]   rep_addr_reg;
    logic                rep_neg_reg;
    logic [WHOLE_W-1:0]  rep_whole_reg;
    logic [TENTH_W-1:0]  rep_tenth_reg;
    logic [HUM_W-1:0]    rep_hum_reg;

    logic                match;
    logic                scan_step;
    logic                issue;
    logic                full;
    logic                due;
    logic [TEMP_W-1:0]   temp_in;
    logic [TIME_W-1:0]   elapsed;
    status_code_t        status_next;
    logic [IDX_W-1:0]    sel_idx;
    logic [IDX_W+INDEX_W-1:0] idx_ext;
    logic                mem_we;
    logic                fill_inc;
    entry_t              wr_data;

    always_comb
    begin
        match     = rd_valid_reg && (rd_data_reg.address == addr_reg);
        scan_step = cmd.scan && !match;
        issue     = scan_step && (rd_idx_reg < fill_reg);
        full      = (fill_reg == DEPTH_CNT);
        temp_in   = {neg_reg, whole_reg, tenth_reg};
        elapsed   = now_reg - rd_data_reg.sent_at;
        due       = !rd_data_reg.sent_once
                    || (rd_data_reg.temperature != temp_in)
                    || (rd_data_reg.humidity != hum_reg)
                    || (elapsed >= {{(TIME_W-IVL_W){1'b0}}, interval_reg});

        stat.hit      = match;
        stat.miss     = !rd_valid_reg && (rd_idx_reg >= fill_reg);
        stat.out_free = !out_valid_reg || !out_stall;

        wr_data.address     = addr_reg;
        wr_data.sent_once   = ready_reg;
        wr_data.temperature = temp_in;
        wr_data.humidity    = hum_reg;
        wr_data.sent_at     = now_reg;

        mem_we   = 1'b0;
        fill_inc = 1'b0;
        if (match)
        begin
            sel_idx = cmp_idx_reg;
            if (!due)
            begin
                status_next = STATUS_SUPPRESSED;
            end
            else if (ready_reg)
            begin
                status_next = STATUS_FORWARDED;
                mem_we      = cmd.commit;
            end
            else
            begin
                status_next = STATUS_SEND_FAILED;
            end
        end
        else if (full)
        begin
            sel_idx     = '0;
            status_next = STATUS_TABLE_FULL;
        end
        else
        begin
            sel_idx     = fill_reg[IDX_W-1:0];
            status_next = ready_reg ? STATUS_FORWARDED : STATUS_SEND_FAILED;
            mem_we      = cmd.commit;
            fill_inc    = cmd.commit;
        end
        idx_ext = {{INDEX_W{1'b0}}, sel_idx};
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[sel_idx] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_RESET;
            fill_reg      <= '0;
            rd_idx_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                interval_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                rd_idx_reg   <= '0;
                rd_valid_reg <= 1'b0;
            end
            else if (scan_step)
            begin
                rd_valid_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
            if (fill_inc)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input capture and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg  <= device_address;
            neg_reg   <= temp_negative;
            whole_reg <= temp_whole;
            tenth_reg <= temp_tenth;
            hum_reg   <= humidity;
            now_reg   <= now_seconds;
            ready_reg <= link_ready;
        end
        if (cmd.commit)
        begin
            status_reg    <= status_next;
            index_reg     <= idx_ext[INDEX_W-1:0];
            rep_addr_reg  <= addr_reg;
            rep_neg_reg   <= neg_reg;
            rep_whole_reg <= whole_reg;
            rep_tenth_reg <= tenth_reg;
            rep_hum_reg   <= hum_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign entry_index     = index_reg;
    assign report_address  = rep_addr_reg;
    assign report_negative = rep_neg_reg;
    assign report_whole    = rep_whole_reg;
    assign report_tenth    = rep_tenth_reg;
    assign report_humidity = rep_hum_reg;

endmodule

`default_nettype wire

FILE: rtl/per_device_report_filter_table.sv
// Per-device report filter table, top level.
// Input channel in_valid/in_stall carries one sensor reading per transfer;
// output channel out_valid/out_stall carries one result per reading.
// cfg_valid/cfg_ready writes the heartbeat interval (cfg_ready is always high);
// write it only while no reading is in flight.
// A reading is held while the table is scanned one entry per cycle from the
// table memory, then a due decision loads the result register and writes
// the entry on a forwarded match or on a miss while the table has room; a new
// reading is taken once the previous one has been decided, even while its
// result still waits.
// If the receiver stalls, the result holds in the output register and the
// next reading stops before its decision until that register is taken.
// Reset empties the table (fill count to zero), sets the heartbeat interval
// to 300 and drops any pending result; no clearing pass is needed.
// Depends on pdrf_pkg, pdrf_ctrl, pdrf_datapath and the macro header.
`default_nettype none
`include "per_device_report_filter_table_macros.svh"

module per_device_report_filter_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [pdrf_pkg::IVL_W-1:0]        cfg_data,
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire [pdrf_pkg::ADDR_W-1:0]       device_address,
    input  wire                              temp_negative,
    input  wire [pdrf_pkg::WHOLE_W-1:0]      temp_whole,
    input  wire [pdrf_pkg::TENTH_W-1:0]      temp_tenth,
    input  wire [pdrf_pkg::HUM_W-1:0]        humidity,
    input  wire [pdrf_pkg::TIME_W-1:0]       now_seconds,
    input  wire                              link_ready,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [pdrf_pkg::STATUS_W-1:0]    status,
    output logic [pdrf_pkg::INDEX_W-1:0]     entry_index,
    output logic [pdrf_pkg::ADDR_W-1:0]      report_address,
    output logic                             report_negative,
    output logic [pdrf_pkg::WHOLE_W-1:0]     report_whole,
    output logic [pdrf_pkg::TENTH_W-1:0]     report_tenth,
    output logic [pdrf_pkg::HUM_W-1:0]       report_humidity
);
    import pdrf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    assign cfg_ready = 1'b1;

    pdrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdrf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .device_address  (device_address),
        .temp_negative   (temp_negative),
        .temp_whole      (temp_whole),
        .temp_tenth      (temp_tenth),
        .humidity        (humidity),
        .now_seconds     (now_seconds),
        .link_ready      (link_ready),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .entry_index     (entry_index),
        .report_address  (report_address),
        .report_negative (report_negative),
        .report_whole    (report_whole),
        .report_tenth    (report_tenth),
        .report_humidity (report_humidity)
    );

    `PDRF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
    `PDRF_ASSERT_NEXT(a_result_after_commit, cmd.commit, out_valid && !in_stall, "commit lost")
    `PDRF_ASSERT_NOW(a_load_commit_apart, cmd.load, !cmd.commit, "load and commit overlap")

endmodule

`default_nettype wire
